// ----- rtl/pps_pkg.sv -----
package pps_pkg;

    localparam int MAX_PEP_LEN = 100;
    localparam int POS_BITS    = 16;

    localparam int MASS_W    = 40;
    localparam int LEN_W     = 7;
    localparam int START_W   = 16;
    localparam int RES_W     = 8;
    localparam int SET_W     = 26;
    localparam int LIDX_W    = 5;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int REG_IDX_W = 3;
    localparam int CNT_W     = 2;

    typedef logic [MASS_W-1:0]   mass_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [START_W-1:0]  start_t;
    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [RES_W-1:0]    res_t;
    typedef logic [SET_W-1:0]    set_t;
    typedef logic [LIDX_W-1:0]   lidx_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    localparam reg_idx_t REG_MASS_TYPE   = 3'd0;
    localparam reg_idx_t REG_CUT_AFTER   = 3'd1;
    localparam reg_idx_t REG_NO_CUT      = 3'd2;
    localparam reg_idx_t REG_MIN_MASS    = 3'd3;
    localparam reg_idx_t REG_MAX_MASS    = 3'd4;

    localparam res_t LETTER_A = 8'h41;
    localparam res_t LETTER_Z = 8'h5A;
    localparam res_t RES_NONE = 8'h00;

    localparam mass_t MASS_MAX = '1;
    localparam len_t  LEN_SAT  = '1;
    localparam len_t  LEN_LIMIT = len_t'(MAX_PEP_LEN - 1);

    localparam mass_t H_AVG  = 40'd66056;
    localparam mass_t H_MONO = 40'd66049;
    localparam mass_t O_AVG  = 40'd1048537;
    localparam mass_t O_MONO = 40'd1048243;

    localparam mass_t WATER_AVG    = O_AVG + H_AVG + H_AVG;
    localparam mass_t WATER_MONO   = O_MONO + H_MONO + H_MONO;
    localparam mass_t WATER_H_AVG  = WATER_AVG + H_AVG;
    localparam mass_t WATER_H_MONO = WATER_MONO + H_MONO;

    localparam mass_t AVG_TAB [SET_W] = '{
        40'd4658220,  40'd7510178,  40'd6759304,  40'd7542446,  40'd8461712,
        40'd9645363,  40'd3738955,  40'd8987678,  40'd7416017,  40'd0,
        40'd8400017,  40'd7416017,  40'd8597836,  40'd7477909,  40'd7480751,
        40'd6364639,  40'd8397175,  40'd10235903, 40'd5706757,  40'd6626023,
        40'd0,        40'd6496751,  40'd12203668, 40'd6553599345, 40'd10693900,
        40'd8429443
    };

    localparam mass_t MONO_TAB [SET_W] = '{
        40'd4655488,  40'd7506162,  40'd6750810,  40'd7538406,  40'd8456935,
        40'd9638276,  40'd3736959,  40'd8982293,  40'd7411077,  40'd0,
        40'd8394831,  40'd7411077,  40'd8587869,  40'd7473917,  40'd7476302,
        40'd6360450,  40'd8392447,  40'd10230242, 40'd5703731,  40'd6622261,
        40'd0,        40'd6492548,  40'd12194894, 40'd6553599345, 40'd10686518,
        40'd8424691
    };

    typedef struct packed {
        logic  mass_type;
        set_t  cut_after_set;
        set_t  no_cut_before_set;
        mass_t min_mass;
        mass_t max_mass;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mass_type:         1'b0,
        cut_after_set:     26'h0020400,
        no_cut_before_set: 26'h0008000,
        min_mass:          40'd13107200,
        max_mass:          40'd6553600000
    };

    typedef struct packed {
        logic   vld;
        start_t start;
        len_t   count;
        mass_t  sum;
        res_t   prev;
        res_t   next;
    } cand_t;

    typedef struct packed {
        start_t start_pos;
        len_t   pep_length;
        mass_t  pep_mass;
        res_t   prev_residue;
        res_t   next_residue;
        logic   last_of_run;
    } rec_t;

    function automatic logic is_letter(res_t r);
        return (r >= LETTER_A) && (r <= LETTER_Z);
    endfunction

    function automatic lidx_t letter_idx(res_t r);
        res_t d;
        d = r - LETTER_A;
        return d[LIDX_W-1:0];
    endfunction

    function automatic logic in_set(set_t s, res_t r);
        return is_letter(r) && s[letter_idx(r)];
    endfunction

    function automatic mass_t residue_mass(res_t r, logic mono);
        lidx_t i;
        i = letter_idx(r);
        if (!is_letter(r))
            return '0;
        return mono ? MONO_TAB[i] : AVG_TAB[i];
    endfunction

    function automatic mass_t sat_add(mass_t a, mass_t b);
        logic [MASS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MASS_W] ? MASS_MAX : s[MASS_W-1:0];
    endfunction

endpackage

// ----- rtl/pps_in_if.sv -----
interface pps_in_if;
    import pps_pkg::*;

    logic valid;
    logic ready;
    res_t residue;
    logic end_of_protein;

    modport source (output valid, output residue, output end_of_protein, input ready);
    modport sink   (input valid, input residue, input end_of_protein, output ready);
endinterface

// ----- rtl/pps_out_if.sv -----
interface pps_out_if;
    import pps_pkg::*;

    logic   valid;
    logic   ready;
    start_t start_pos;
    len_t   pep_length;
    mass_t  pep_mass;
    res_t   prev_residue;
    res_t   next_residue;
    logic   last_of_run;

    modport source (
        output valid, output start_pos, output pep_length, output pep_mass,
        output prev_residue, output next_residue, output last_of_run, input ready
    );
    modport sink (
        input valid, input start_pos, input pep_length, input pep_mass,
        input prev_residue, input next_residue, input last_of_run, output ready
    );
endinterface

// ----- rtl/pps_cfg_regs.sv -----
module pps_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pps_pkg::ADDR_W-1:0]  paddr,
    input  logic [pps_pkg::DATA_W-1:0]  pwdata,
    output logic [pps_pkg::DATA_W-1:0]  prdata,
    output pps_pkg::cfg_t               cfg
);
    import pps_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MASS_TYPE: cfg_next.mass_type         = pwdata[0];
                REG_CUT_AFTER: cfg_next.cut_after_set     = pwdata[SET_W-1:0];
                REG_NO_CUT:    cfg_next.no_cut_before_set = pwdata[SET_W-1:0];
                REG_MIN_MASS:  cfg_next.min_mass          = pwdata[MASS_W-1:0];
                REG_MAX_MASS:  cfg_next.max_mass          = pwdata[MASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MASS_TYPE: prdata = DATA_W'(cfg_reg.mass_type);
            REG_CUT_AFTER: prdata = DATA_W'(cfg_reg.cut_after_set);
            REG_NO_CUT:    prdata = DATA_W'(cfg_reg.no_cut_before_set);
            REG_MIN_MASS:  prdata = DATA_W'(cfg_reg.min_mass);
            REG_MAX_MASS:  prdata = DATA_W'(cfg_reg.max_mass);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// ----- rtl/pps_split.sv -----
module pps_split (
    input  logic           clk,
    input  logic           rst_n,
    pps_in_if.sink         residue_ch,
    input  pps_pkg::cfg_t  cfg,
    output pps_pkg::cand_t cand_a,
    output pps_pkg::cand_t cand_b,
    output logic           cand_vld,
    input  logic           cand_ready
);
    import pps_pkg::*;

    logic  s0_vld_reg, s0_vld_next;
    res_t  s0_res_reg;
    logic  s0_eop_reg;
    logic  s0_ready, s1_load, in_take;

    mass_t mass_sum_reg, mass_sum_next;
    pos_t  pep_start_reg, pep_start_next;
    pos_t  position_reg, position_next;
    len_t  pep_count_reg, pep_count_next;
    res_t  held_res_reg, held_res_next;
    logic  held_vld_reg, held_vld_next;
    res_t  before_reg, before_next;

    logic  cand_vld_reg, cand_vld_next;
    cand_t cand_a_reg, cand_b_reg;
    cand_t cand_a_next, cand_b_next;

    logic  cut;
    mass_t base_sum, new_sum;
    len_t  base_count, new_count;
    pos_t  start1, position1;
    res_t  before1;

    assign s1_load  = s0_vld_reg && (!cand_vld_reg || cand_ready);
    assign s0_ready = !s0_vld_reg || s1_load;
    assign in_take  = residue_ch.valid && s0_ready;

    assign residue_ch.ready = s0_ready;
    assign cand_vld = cand_vld_reg;
    assign cand_a   = cand_a_reg;
    assign cand_b   = cand_b_reg;

    always_comb
    begin
        if (in_take)
            s0_vld_next = 1'b1;
        else if (s1_load)
            s0_vld_next = 1'b0;
        else
            s0_vld_next = s0_vld_reg;

        if (s1_load)
            cand_vld_next = 1'b1;
        else if (cand_ready)
            cand_vld_next = 1'b0;
        else
            cand_vld_next = cand_vld_reg;
    end

    always_comb
    begin
        cut = held_vld_reg && in_set(cfg.cut_after_set, held_res_reg) &&
              !in_set(cfg.no_cut_before_set, s0_res_reg);

        base_sum   = cut ? '0 : mass_sum_reg;
        base_count = cut ? '0 : pep_count_reg;
        start1     = cut ? position_reg : pep_start_reg;
        before1    = cut ? held_res_reg : before_reg;
        new_sum    = sat_add(base_sum, residue_mass(s0_res_reg, cfg.mass_type));
        new_count  = (base_count == LEN_SAT) ? base_count : base_count + len_t'(1);
        position1  = position_reg + pos_t'(1);

        cand_a_next.vld   = cut;
        cand_a_next.start = start_t'(pep_start_reg);
        cand_a_next.count = pep_count_reg;
        cand_a_next.sum   = mass_sum_reg;
        cand_a_next.prev  = before_reg;
        cand_a_next.next  = s0_res_reg;

        cand_b_next.vld   = s0_eop_reg;
        cand_b_next.start = start_t'(start1);
        cand_b_next.count = new_count;
        cand_b_next.sum   = new_sum;
        cand_b_next.prev  = before1;
        cand_b_next.next  = RES_NONE;

        mass_sum_next  = mass_sum_reg;
        pep_start_next = pep_start_reg;
        position_next  = position_reg;
        pep_count_next = pep_count_reg;
        held_res_next  = held_res_reg;
        held_vld_next  = held_vld_reg;
        before_next    = before_reg;

        if (s1_load)
        begin
            if (s0_eop_reg)
            begin
                mass_sum_next  = '0;
                pep_start_next = '0;
                position_next  = '0;
                pep_count_next = '0;
                held_res_next  = RES_NONE;
                held_vld_next  = 1'b0;
                before_next    = RES_NONE;
            end
            else
            begin
                mass_sum_next  = new_sum;
                pep_start_next = start1;
                position_next  = position1;
                pep_count_next = new_count;
                held_res_next  = s0_res_reg;
                held_vld_next  = 1'b1;
                before_next    = before1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg    <= 1'b0;
            cand_vld_reg  <= 1'b0;
            mass_sum_reg  <= '0;
            pep_start_reg <= '0;
            position_reg  <= '0;
            pep_count_reg <= '0;
            held_res_reg  <= RES_NONE;
            held_vld_reg  <= 1'b0;
            before_reg    <= RES_NONE;
        end
        else
        begin
            s0_vld_reg    <= s0_vld_next;
            cand_vld_reg  <= cand_vld_next;
            mass_sum_reg  <= mass_sum_next;
            pep_start_reg <= pep_start_next;
            position_reg  <= position_next;
            pep_count_reg <= pep_count_next;
            held_res_reg  <= held_res_next;
            held_vld_reg  <= held_vld_next;
            before_reg    <= before_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_res_reg <= residue_ch.residue;
            s0_eop_reg <= residue_ch.end_of_protein;
        end
        if (s1_load)
        begin
            cand_a_reg <= cand_a_next;
            cand_b_reg <= cand_b_next;
        end
    end

endmodule

// ----- rtl/pps_emit.sv -----
module pps_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  pps_pkg::cfg_t  cfg,
    input  pps_pkg::cand_t cand_a,
    input  pps_pkg::cand_t cand_b,
    input  logic           cand_vld,
    output logic           cand_ready,
    pps_out_if.source      peptide_ch
);
    import pps_pkg::*;

    mass_t water, water_h;
    mass_t mass_a, mass_b, mh_a, mh_b;
    logic  pass_a, pass_b;
    rec_t  rec_a, rec_b;

    cnt_t  cnt_reg, cnt_next;
    rec_t  e0_reg, e0_next;
    rec_t  e1_reg, e1_next;
    logic  pop, free, push;

    always_comb
    begin
        water   = cfg.mass_type ? WATER_MONO   : WATER_AVG;
        water_h = cfg.mass_type ? WATER_H_MONO : WATER_H_AVG;

        mass_a = sat_add(cand_a.sum, water);
        mh_a   = sat_add(cand_a.sum, water_h);
        mass_b = sat_add(cand_b.sum, water);
        mh_b   = sat_add(cand_b.sum, water_h);

        pass_a = cand_a.vld && (mh_a >= cfg.min_mass) && (mh_a <= cfg.max_mass) &&
                 (cand_a.count < LEN_LIMIT);
        pass_b = cand_b.vld && (mh_b >= cfg.min_mass) && (mh_b <= cfg.max_mass) &&
                 (cand_b.count < LEN_LIMIT);

        rec_a.start_pos    = cand_a.start;
        rec_a.pep_length   = cand_a.count;
        rec_a.pep_mass     = mass_a;
        rec_a.prev_residue = cand_a.prev;
        rec_a.next_residue = cand_a.next;
        rec_a.last_of_run  = !pass_b;

        rec_b.start_pos    = cand_b.start;
        rec_b.pep_length   = cand_b.count;
        rec_b.pep_mass     = mass_b;
        rec_b.prev_residue = cand_b.prev;
        rec_b.next_residue = cand_b.next;
        rec_b.last_of_run  = 1'b1;
    end

    assign pop        = (cnt_reg != '0) && peptide_ch.ready;
    assign free       = (cnt_reg == '0) || ((cnt_reg == cnt_t'(1)) && pop);
    assign push       = cand_vld && free;
    assign cand_ready = free;

    always_comb
    begin
        cnt_next = cnt_reg;
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        if (pop)
        begin
            cnt_next = cnt_reg - cnt_t'(1);
            e0_next  = e1_reg;
        end
        if (push)
        begin
            cnt_next = cnt_t'(pass_a) + cnt_t'(pass_b);
            e0_next  = pass_a ? rec_a : rec_b;
            e1_next  = rec_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign peptide_ch.valid        = (cnt_reg != '0);
    assign peptide_ch.start_pos    = e0_reg.start_pos;
    assign peptide_ch.pep_length   = e0_reg.pep_length;
    assign peptide_ch.pep_mass     = e0_reg.pep_mass;
    assign peptide_ch.prev_residue = e0_reg.prev_residue;
    assign peptide_ch.next_residue = e0_reg.next_residue;
    assign peptide_ch.last_of_run  = e0_reg.last_of_run;

endmodule

// ----- rtl/protease_peptide_splitter_core.sv -----
// Peptide splitter: cuts a protein residue stream into peptide records.
// residue_ch takes one residue letter per transaction, end_of_protein on the
// final residue of each protein. peptide_ch gives one peptide record per
// transaction: start, length, mass with water, flanking residues, and
// last_of_run on the final record caused by one input residue.
// The APB port writes the mass table select, the cut letter sets and the
// mass window; registers sit at byte addresses 0, 8, 16, 24, 32, and the user
// must see that they are written only while the block is idle (not enforced).
// Throughput is one residue per cycle while peptide_ch is ready; the only other
// slow case is a residue that yields two records, which holds back the next
// candidate until the second record goes out. The block cuts after a residue
// only once it sees the next one, so a peptide's record follows the residue
// after its last one. A taken residue passes the input register, then the
// candidate register (state update, residue mass add), then result buffer (mass window).
// Reset empties every stage and clears the open peptide; registers return
// to R/K cut after, P blocking, average masses, 200 to 100000 Da.
// When peptide_ch stalls, the two-entry result buffer holds and the stages
// behind it fill, after which residue_ch.ready drops.
module protease_peptide_splitter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    pps_in_if.sink                      residue_ch,
    pps_out_if.source                   peptide_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pps_pkg::ADDR_W-1:0]  paddr,
    input  logic [pps_pkg::DATA_W-1:0]  pwdata,
    output logic [pps_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import pps_pkg::*;

    cfg_t  cfg;
    cand_t cand_a, cand_b;
    logic  cand_vld, cand_ready;

    assign pready = 1'b1;

    pps_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pps_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .residue_ch (residue_ch),
        .cfg        (cfg),
        .cand_a     (cand_a),
        .cand_b     (cand_b),
        .cand_vld   (cand_vld),
        .cand_ready (cand_ready)
    );

    pps_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cand_a     (cand_a),
        .cand_b     (cand_b),
        .cand_vld   (cand_vld),
        .cand_ready (cand_ready),
        .peptide_ch (peptide_ch)
    );

endmodule

// ----- rtl/pps_checker.sv -----
module pps_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  out_last,
    input logic [pps_pkg::MASS_W-1:0]  out_mass,
    input logic [pps_pkg::START_W-1:0] out_start
);
    import pps_pkg::*;

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("peptide channel valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("peptide record dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_mass) && $stable(out_start))
        else $error("peptide record changed while stalled");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("second record of a run missing");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("residue channel stalled with empty result buffer");

endmodule

bind protease_peptide_splitter_core pps_checker u_pps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (residue_ch.ready),
    .out_valid (peptide_ch.valid),
    .out_ready (peptide_ch.ready),
    .out_last  (peptide_ch.last_of_run),
    .out_mass  (peptide_ch.pep_mass),
    .out_start (peptide_ch.start_pos)
);

// ----- sim/protease_peptide_splitter_core_tb.sv -----
`timescale 1ns / 100ps

module protease_peptide_splitter_core_tb;
    import pps_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_SET   = 270;
    localparam int TAIL_PROTEIN    = 40;

    class peptide_scoreboard;
        rec_t  expected_q[$];
        int    fail_count;

        logic  mono;
        set_t  cut_set;
        set_t  block_set;
        mass_t lo_mass;
        mass_t hi_mass;

        mass_t open_mass;
        pos_t  open_start;
        pos_t  next_pos;
        len_t  open_len;
        res_t  held;
        logic  held_ok;
        res_t  flank_before;

        function new();
            fail_count = 0;
            mono       = CFG_RESET.mass_type;
            cut_set    = CFG_RESET.cut_after_set;
            block_set  = CFG_RESET.no_cut_before_set;
            lo_mass    = CFG_RESET.min_mass;
            hi_mass    = CFG_RESET.max_mass;
            clear_open();
        endfunction

        function void clear_open();
            open_mass    = '0;
            open_start   = '0;
            next_pos     = '0;
            open_len     = '0;
            held         = RES_NONE;
            held_ok      = 1'b0;
            flank_before = RES_NONE;
        endfunction

        function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MASS_TYPE: mono      = value[0];
                REG_CUT_AFTER: cut_set   = value[SET_W-1:0];
                REG_NO_CUT:    block_set = value[SET_W-1:0];
                REG_MIN_MASS:  lo_mass   = value[MASS_W-1:0];
                REG_MAX_MASS:  hi_mass   = value[MASS_W-1:0];
                default: ;
            endcase
        endfunction

        function mass_t add_sat(mass_t a, mass_t b);
            logic [MASS_W:0] s;
            s = a;
            s = s + b;
            return s[MASS_W] ? MASS_MAX : s[MASS_W-1:0];
        endfunction

        function logic member(set_t s, res_t r);
            if (r < LETTER_A || r > LETTER_Z)
                return 1'b0;
            return s[r - LETTER_A];
        endfunction

        function mass_t weight(res_t r);
            if (r < LETTER_A || r > LETTER_Z)
                return '0;
            return mono ? MONO_TAB[r - LETTER_A] : AVG_TAB[r - LETTER_A];
        endfunction

        function void close_open(res_t next, ref rec_t batch[$]);
            mass_t h;
            mass_t water;
            mass_t with_water;
            mass_t with_proton;
            rec_t  rec;
            h           = mono ? H_MONO : H_AVG;
            water       = add_sat(mono ? O_MONO : O_AVG, h + h);
            with_water  = add_sat(open_mass, water);
            with_proton = add_sat(with_water, h);
            if (with_proton >= lo_mass && with_proton <= hi_mass
                && int'(open_len) + 1 < MAX_PEP_LEN)
            begin
                rec.start_pos    = start_t'(open_start);
                rec.pep_length   = open_len;
                rec.pep_mass     = with_water;
                rec.prev_residue = flank_before;
                rec.next_residue = next;
                rec.last_of_run  = 1'b0;
                batch.push_back(rec);
            end
        endfunction

        function void note_residue(res_t r, logic eop);
            rec_t batch[$];
            if (held_ok && member(cut_set, held) && !member(block_set, r))
            begin
                close_open(r, batch);
                flank_before = held;
                open_start   = next_pos;
                open_mass    = '0;
                open_len     = '0;
            end
            open_mass = add_sat(open_mass, weight(r));
            if (open_len != LEN_SAT)
                open_len = open_len + 1'b1;
            held     = r;
            held_ok  = 1'b1;
            next_pos = next_pos + 1'b1;
            if (eop)
            begin
                close_open(RES_NONE, batch);
                clear_open();
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last_of_run = 1'b1;
            foreach (batch[i])
                expected_q.push_back(batch[i]);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_record(rec_t got);
            rec_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected peptide record, start_pos %0d length %0d",
                       got.start_pos, got.pep_length);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("start_pos", want.start_pos, got.start_pos);
            compare_field("pep_length", want.pep_length, got.pep_length);
            compare_field("pep_mass", want.pep_mass, got.pep_mass);
            compare_field("prev_residue", want.prev_residue, got.prev_residue);
            compare_field("next_residue", want.next_residue, got.next_residue);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pps_in_if  residue_bus ();
    pps_out_if peptide_bus ();

    peptide_scoreboard book = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_reqs;
    int items_sent;
    int quiet_cycles;

    protease_peptide_splitter_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .residue_ch (residue_bus),
        .peptide_ch (peptide_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin : receiver
        int stall_left;
        int served;
        stall_left = 0;
        served     = 0;
        peptide_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_off_reqs)
            begin
                served     = hold_off_reqs;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                peptide_bus.ready <= 1'b0;
            end
            else
                peptide_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        rec_t got;
        logic moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (peptide_bus.valid && peptide_bus.ready)
            begin
                got.start_pos    = peptide_bus.start_pos;
                got.pep_length   = peptide_bus.pep_length;
                got.pep_mass     = peptide_bus.pep_mass;
                got.prev_residue = peptide_bus.prev_residue;
                got.next_residue = peptide_bus.next_residue;
                got.last_of_run  = peptide_bus.last_of_run;
                book.check_record(got);
                moved = 1'b1;
            end
            if (residue_bus.valid && residue_bus.ready)
            begin
                book.note_residue(residue_bus.residue, residue_bus.end_of_protein);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_residue(input res_t r, input logic eop);
        while ($urandom_range(99) < send_idle_pct)
        begin
            residue_bus.valid <= 1'b0;
            @(posedge clk);
        end
        residue_bus.valid          <= 1'b1;
        residue_bus.residue        <= r;
        residue_bus.end_of_protein <= eop;
        do @(posedge clk); while (!residue_bus.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_residue(res_t'(s[i]), i == s.len() - 1);
    endtask

    function automatic res_t pick_residue();
        int k;
        k = $urandom_range(99);
        if (k < 7)
            return res_t'($urandom_range(255));
        if (k < 15)
            return $urandom_range(1) ? res_t'("R") : res_t'("K");
        if (k < 20)
            return res_t'("P");
        return LETTER_A + res_t'($urandom_range(25));
    endfunction

    task automatic send_random_protein();
        int   len;
        logic long_run;
        res_t r;
        long_run = ($urandom_range(19) == 0);
        len      = long_run ? $urandom_range(100, 180) : $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
        begin
            if (long_run)
                r = $urandom_range(1) ? res_t'("G") : res_t'("a");
            else
                r = pick_residue();
            send_residue(r, i == len - 1);
        end
    endtask

    task automatic drain();
        residue_bus.valid <= 1'b0;
        @(negedge clk);
        while (book.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        book.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(input cfg_t c);
        apb_write(REG_MASS_TYPE, DATA_W'(c.mass_type));
        apb_write(REG_CUT_AFTER, DATA_W'(c.cut_after_set));
        apb_write(REG_NO_CUT, DATA_W'(c.no_cut_before_set));
        apb_write(REG_MIN_MASS, DATA_W'(c.min_mass));
        apb_write(REG_MAX_MASS, DATA_W'(c.max_mass));
    endtask

    task automatic run_random(input int count, input logic pressure);
        int first;
        int stalled;
        int paused;
        first   = items_sent;
        stalled = 0;
        paused  = 0;
        while (items_sent - first < count)
        begin
            if (pressure && !stalled && items_sent - first > 60)
            begin
                hold_off_reqs++;
                stalled = 1;
            end
            if (pressure && !paused && items_sent - first > 180)
            begin
                drain();
                paused = 1;
            end
            send_random_protein();
        end
    endtask

    initial
    begin : stimulus
        cfg_t c;
        send_idle_pct = 35;
        recv_idle_pct = 66;
        hold_off_reqs = 0;
        items_sent    = 0;
        quiet_cycles  = 0;
        rst_n                      <= 1'b0;
        psel                       <= 1'b0;
        penable                    <= 1'b0;
        pwrite                     <= 1'b0;
        paddr                      <= '0;
        pwdata                     <= '0;
        residue_bus.valid          <= 1'b0;
        residue_bus.residue        <= RES_NONE;
        residue_bus.end_of_protein <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("GRKE");
        send_text("WWKW");
        send_text("W");
        send_text("aJUXW");
        send_text("MKPAR");
        send_residue(8'h00, 1'b0);
        send_residue(8'hFF, 1'b1);

        run_random(ITEMS_PER_SET, 1'b1);

        drain();
        c           = CFG_RESET;
        c.mass_type = 1'b1;
        c.min_mass  = '0;
        c.max_mass  = MASS_MAX;
        load_setting(c);
        for (int i = 0; i < 170; i++)
            send_residue(res_t'("X"), i == 169);
        run_random(ITEMS_PER_SET - 170, 1'b0);

        drain();
        send_idle_pct       = 66;
        recv_idle_pct       = 35;
        c.mass_type         = 1'b0;
        c.cut_after_set     = set_t'($urandom);
        c.no_cut_before_set = set_t'($urandom);
        c.min_mass          = mass_t'($urandom_range(200, 500)) << 16;
        c.max_mass          = mass_t'($urandom_range(1000, 5000)) << 16;
        load_setting(c);
        run_random(ITEMS_PER_SET, 1'b0);

        drain();
        c.mass_type         = 1'b1;
        c.cut_after_set     = '1;
        c.no_cut_before_set = '0;
        c.min_mass          = '0;
        c.max_mass          = MASS_MAX;
        load_setting(c);
        run_random(ITEMS_PER_SET, 1'b0);

        drain();
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        c.mass_type         = 1'b0;
        c.no_cut_before_set = '1;
        load_setting(c);
        run_random(ITEMS_PER_SET, 1'b0);

        drain();
        c.cut_after_set = '0;
        c.min_mass      = MASS_MAX;
        c.max_mass      = '0;
        load_setting(c);
        run_random(60, 1'b0);

        drain();
        c                   = CFG_RESET;
        c.cut_after_set     = set_t'(1) << ("R" - LETTER_A);
        c.no_cut_before_set = '0;
        c.min_mass          = '0;
        c.max_mass          = MASS_MAX;
        load_setting(c);
        for (int i = 0; i < TAIL_PROTEIN; i++)
            send_residue((i % 20 == 19) ? res_t'("R") : res_t'("G"), i == TAIL_PROTEIN - 1);

        drain();
        if (book.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
